/* rtl/barrier_call_spread_smoothing_defines.svh */
// Assertion macros used by the checker file.
`ifndef BARRIER_CALL_SPREAD_SMOOTHING_DEFINES_SVH
`define BARRIER_CALL_SPREAD_SMOOTHING_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define BCSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define BCSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bcss_pkg.sv */
package bcss_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [16:0] ONE_Q  = 17'h10000;
  localparam logic [16:0] HALF_Q = 17'h08000;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PATH = 1'b1;

  localparam logic [1:0] MODE_MONO  = 2'd0;
  localparam logic [1:0] MODE_WORST = 2'd1;
  localparam logic [1:0] MODE_BEST  = 2'd2;

  localparam logic [2:0] REG_NOTIONAL = 3'd0;
  localparam logic [2:0] REG_GEARING  = 3'd1;
  localparam logic [2:0] REG_DOWN     = 3'd2;
  localparam logic [2:0] REG_OFF      = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  typedef struct packed {
    logic [47:0] notional;
    logic [31:0] gearing;
    logic        down;
    logic        off;
    logic [1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [2:0]         idx;
    logic signed [31:0] barrier;
    logic [47:0]        cap;
    logic [31:0]        smin;
    logic [31:0]        smax;
    logic signed [31:0] gain;
    logic signed [31:0] perf;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] barrier;
    logic [47:0]        cap;
    logic [31:0]        lo;
    logic [31:0]        hi;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MULLO,
    ST_MULHI,
    ST_DIVSET,
    ST_DIV,
    ST_CLAMP,
    ST_FRACSET,
    ST_FRAC,
    ST_YSEL,
    ST_SPREAD,
    ST_COMBINE
  } bstate_e;

  // index modulo table depth, by repeated subtraction on a 3-bit value
  function automatic logic [5:0] idx_mod(logic [2:0] v, int unsigned m);
    int r;
    r = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= int'(m)) begin
        r = r - int'(m);
      end
    end
    return 6'(r);
  endfunction

endpackage

/* rtl/bcss_ram.sv */
module bcss_ram #(
  parameter int unsigned WIDTH = 144,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bcss_front.sv */
module bcss_front (
  input  logic               action_i,
  input  logic [2:0]         underlying_index_i,
  input  logic signed [31:0] barrier_level_i,
  input  logic [31:0]        delta_max_i,
  input  logic [31:0]        fx_rate_i,
  input  logic [31:0]        spread_min_i,
  input  logic [31:0]        spread_max_i,
  input  logic signed [31:0] regressed_gain_i,
  input  logic signed [31:0] underlying_performance_i,
  input  logic               last_underlying_i,
  output bcss_pkg::item_t    item_o
);
  import bcss_pkg::*;

  logic [63:0] cap_full;

  // delta cap in Q32.F; the 64-bit product shifted by F always fits 48 bits
  assign cap_full = delta_max_i * fx_rate_i;

  always_comb begin
    item_o         = '0;
    item_o.action  = action_i;
    item_o.last    = last_underlying_i;
    if (action_i == ACT_LOAD) begin
      item_o.idx     = underlying_index_i;
      item_o.barrier = barrier_level_i;
      item_o.cap     = 48'(cap_full >> FRAC_BITS);
      item_o.smin    = spread_min_i;
      item_o.smax    = spread_max_i;
    end else begin
      item_o.gain = regressed_gain_i;
      item_o.perf = underlying_performance_i;
    end
  end

endmodule

/* rtl/bcss_fifo.sv */
module bcss_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bcss_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output bcss_pkg::item_t data_o,
  output logic            empty_o
);
  import bcss_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? !wp_q : wp_q;
    rp_d  = do_pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

/* rtl/bcss_back.sv */
module bcss_back #(
  parameter int unsigned MAX_UNDERLYINGS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcss_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  bcss_pkg::item_t    q_data_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  input  logic               res_pop_i,
  output logic [16:0]        element_smoothing_o,
  output logic [16:0]        path_smoothing_o,
  output logic signed [31:0] path_performance_o,
  output logic               path_done_o
);
  import bcss_pkg::*;

  localparam int unsigned IW = (MAX_UNDERLYINGS > 1) ? $clog2(MAX_UNDERLYINGS) : 1;
  localparam logic signed [33:0] PP_MAX = 34'sd2147483647;
  localparam logic signed [33:0] PP_MIN = -34'sd2147483648;

  bstate_e state_q, state_d;

  item_t              item_q, item_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic signed [32:0] diff_q, diff_d;
  logic signed [33:0] perf_q, perf_d;
  logic [33:0]        mag_q, mag_d;
  logic [31:0]        ag_q, ag_d;
  logic [79:0]        prod_q, prod_d;
  logic [48:0]        rem_q, rem_d;
  logic [31:0]        quo_q, quo_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [47:0]        eps_q, eps_d;
  logic [16:0]        y_q, y_d;
  logic [16:0]        s_q, s_d;
  logic [16:0]        run_prod_q, run_prod_d;
  logic signed [32:0] run_ext_q, run_ext_d;
  logic               out_valid_q, out_valid_d;
  logic [16:0]        es_q, es_d, ps_q, ps_d;
  logic signed [31:0] pp_q, pp_d;
  logic               pd_q, pd_d;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  entry_t             ent_w, ent_r;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // combinational helpers
  logic signed [32:0] diff_c;
  logic signed [33:0] perf_c;
  logic signed [32:0] gain_c;
  logic [63:0]        mul_lo_c;
  logic [47:0]        mul_hi_c;
  logic               sat_c;
  logic [48:0]        rem2_c;
  logic [31:0]        min_c, clamp_c;
  logic [63:0]        eps_full_c;
  logic               step_c, perf_ge0_c, perf_le0_c, shift_c;
  logic [16:0]        op_c, t_c, bprod_c, f_c, nprod_c;
  logic [33:0]        sq_c, pm_c;
  logic signed [32:0] bext_c, next_c;
  logic signed [33:0] pext_c;
  logic               first_c, take_c, wb_c;

  assign ent_r = ram_rdata;

  bcss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_UNDERLYINGS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ent_w),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sat_c      = (prod_q[79:32] >= ent_r.cap);
  assign step_c     = cfg_i.off || (cfg_i.gearing == 32'd0) || (eps_q == 48'd0);
  assign perf_ge0_c = !perf_q[33];
  assign perf_le0_c = perf_q[33] || (perf_q == 34'sd0);
  assign take_c     = ((cfg_i.mode == MODE_WORST) && !cfg_i.down) ||
                      ((cfg_i.mode == MODE_BEST) && cfg_i.down);
  assign wb_c       = (cfg_i.mode == MODE_WORST) || (cfg_i.mode == MODE_BEST);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && !out_valid_q && (q_data_i.action == ACT_PATH)) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_MULLO;
      ST_MULLO:  state_d = ST_MULHI;
      ST_MULHI:  state_d = ST_DIVSET;
      ST_DIVSET: state_d = sat_c ? ST_CLAMP : ST_DIV;
      ST_DIV:    state_d = (cnt_q == 5'd0) ? ST_CLAMP : ST_DIV;
      ST_CLAMP:  state_d = ST_FRACSET;
      ST_FRACSET: begin
        if (step_c) begin
          state_d = ST_COMBINE;
        end else if ({14'd0, mag_q} >= eps_q) begin
          state_d = ST_YSEL;
        end else begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC:    state_d = (cnt_q == 5'd0) ? ST_YSEL : ST_FRAC;
      ST_YSEL:    state_d = ST_SPREAD;
      ST_SPREAD:  state_d = ST_COMBINE;
      ST_COMBINE: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d      = item_q;
    pos_d       = pos_q;
    diff_d      = diff_q;
    perf_d      = perf_q;
    mag_d       = mag_q;
    ag_d        = ag_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    eps_d       = eps_q;
    y_d         = y_q;
    s_d         = s_q;
    run_prod_d  = run_prod_q;
    run_ext_d   = run_ext_q;
    out_valid_d = out_valid_q;
    es_d        = es_q;
    ps_d        = ps_q;
    pp_d        = pp_q;
    pd_d        = pd_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = IW'(idx_mod(q_data_i.idx, MAX_UNDERLYINGS));
    ram_raddr   = pos_q;
    ent_w.barrier = q_data_i.barrier;
    ent_w.cap     = q_data_i.cap;
    ent_w.lo      = q_data_i.smin;
    ent_w.hi      = q_data_i.smax;

    diff_c   = $signed({item_q.perf[31], item_q.perf}) -
               $signed({ent_r.barrier[31], ent_r.barrier});
    perf_c   = cfg_i.down ? -$signed({diff_c[32], diff_c}) : $signed({diff_c[32], diff_c});
    gain_c   = $signed({item_q.gain[31], item_q.gain});
    mul_lo_c = ag_q * cfg_i.notional[31:0];
    mul_hi_c = ag_q * cfg_i.notional[47:32];
    rem2_c   = '0;
    min_c    = (quo_q < ent_r.hi) ? quo_q : ent_r.hi;
    clamp_c  = (min_c < ent_r.lo) ? ent_r.lo : min_c;
    eps_full_c = clamp_c * cfg_i.gearing;
    shift_c  = !item_q.gain[31] || (cfg_i.notional == 48'd0);
    op_c     = (y_q <= HALF_Q) ? y_q : ONE_Q - y_q;
    sq_c     = op_c * op_c;
    t_c      = 17'(sq_c >> (FRAC_BITS - 1));
    first_c  = (pos_q == '0);
    bprod_c  = first_c ? ONE_Q : run_prod_q;
    bext_c   = first_c ? diff_q : run_ext_q;
    f_c      = take_c ? s_q : ONE_Q - s_q;
    pm_c     = bprod_c * f_c;
    nprod_c  = bprod_c;
    next_c   = bext_c;
    pext_c   = '0;

    if (out_valid_q && res_pop_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          if (q_data_i.action == ACT_LOAD) begin
            ram_we      = 1'b1;
            out_valid_d = 1'b1;
            es_d        = '0;
            ps_d        = '0;
            pp_d        = '0;
            pd_d        = 1'b0;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_READ: begin
        diff_d = diff_c;
        perf_d = perf_c;
        mag_d  = perf_c[33] ? 34'(-perf_c) : 34'(perf_c);
        ag_d   = gain_c[32] ? 32'(-gain_c) : 32'(gain_c);
      end
      ST_MULLO: begin
        prod_d = {16'd0, mul_lo_c};
      end
      ST_MULHI: begin
        prod_d = prod_q + {mul_hi_c, 32'd0};
      end
      ST_DIVSET: begin
        // quotient would need more than 32 bits (also covers a zero cap)
        if (sat_c) begin
          quo_d = '1;
        end else begin
          rem_d = {1'b0, prod_q[79:32]};
          quo_d = '0;
          cnt_d = 5'd31;
        end
      end
      ST_DIV: begin
        rem2_c = {rem_q[47:0], prod_q[31]};
        prod_d = prod_q << 1;
        if (rem2_c >= {1'b0, ent_r.cap}) begin
          rem_d = rem2_c - {1'b0, ent_r.cap};
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem2_c;
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
      end
      ST_CLAMP: begin
        eps_d = 48'(eps_full_c >> FRAC_BITS);
      end
      ST_FRACSET: begin
        if (step_c) begin
          s_d = perf_ge0_c ? ONE_Q : '0;
        end else if ({14'd0, mag_q} >= eps_q) begin
          quo_d = 32'(ONE_Q);
        end else begin
          rem_d = 49'(mag_q);
          quo_d = '0;
          cnt_d = 5'(FRAC_BITS - 1);
        end
      end
      ST_FRAC: begin
        rem2_c = {rem_q[47:0], 1'b0};
        if (rem2_c >= {1'b0, eps_q}) begin
          rem_d = rem2_c - {1'b0, eps_q};
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem2_c;
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
      end
      ST_YSEL: begin
        if (shift_c) begin
          y_d = perf_ge0_c ? ONE_Q : ONE_Q - quo_q[16:0];
        end else begin
          y_d = perf_le0_c ? '0 : quo_q[16:0];
        end
      end
      ST_SPREAD: begin
        s_d = (y_q <= HALF_Q) ? t_c : ONE_Q - t_c;
      end
      ST_COMBINE: begin
        if (wb_c) begin
          nprod_c = (f_c == ONE_Q) ? bprod_c : 17'(pm_c >> FRAC_BITS);
          if ((cfg_i.mode == MODE_WORST) && (diff_q < bext_c)) begin
            next_c = diff_q;
          end
          if ((cfg_i.mode == MODE_BEST) && (diff_q > bext_c)) begin
            next_c = diff_q;
          end
        end else begin
          nprod_c = first_c ? s_q : run_prod_q;
        end
        run_prod_d  = nprod_c;
        run_ext_d   = next_c;
        out_valid_d = 1'b1;
        es_d        = s_q;
        if (item_q.last) begin
          pext_c = cfg_i.down ? -$signed({next_c[32], next_c}) :
                                $signed({next_c[32], next_c});
          ps_d   = (wb_c && !take_c) ? ONE_Q - nprod_c : nprod_c;
          if (pext_c > PP_MAX) begin
            pp_d = 32'sh7FFFFFFF;
          end else if (pext_c < PP_MIN) begin
            pp_d = 32'sh80000000;
          end else begin
            pp_d = pext_c[31:0];
          end
          pd_d  = 1'b1;
          pos_d = '0;
        end else begin
          ps_d  = '0;
          pp_d  = '0;
          pd_d  = 1'b0;
          pos_d = (pos_q == IW'(MAX_UNDERLYINGS - 1)) ? '0 : pos_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      run_prod_q  <= ONE_Q;
      run_ext_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      run_prod_q  <= run_prod_d;
      run_ext_q   <= run_ext_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    diff_q <= diff_d;
    perf_q <= perf_d;
    mag_q  <= mag_d;
    ag_q   <= ag_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    eps_q  <= eps_d;
    y_q    <= y_d;
    s_q    <= s_d;
    es_q   <= es_d;
    ps_q   <= ps_d;
    pp_q   <= pp_d;
    pd_q   <= pd_d;
  end

  assign res_valid_o         = out_valid_q;
  assign element_smoothing_o = es_q;
  assign path_smoothing_o    = ps_q;
  assign path_performance_o  = pp_q;
  assign path_done_o         = pd_q;

endmodule

/* rtl/barrier_call_spread_smoothing.sv */
// Call-spread barrier smoothing. Items enter through a push/full queue port and
// land in a two-entry queue, so up to two items are still taken while a result
// waits in the output register. A load item writes one table entry; its
// all-zero result is registered once the back end pops the item from the queue
// head. A path item runs a 32-step bit-serial divider that forms the spread
// width ratio and a 16-step one that forms the fraction of the width. A
// saturated ratio skips the 32 divide steps, a step-only element skips the
// fraction, and a fraction clipped to one skips its 16 steps. The back end
// picks up the next item in the cycle after the waiting result is taken.
// One item is worked on at a time.
// Configuration (64-bit APB, register i at byte 8*i) must be written while idle.
module barrier_call_spread_smoothing #(
  parameter int unsigned MAX_UNDERLYINGS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [2:0]         underlying_index_i,
  input  logic signed [31:0] barrier_level_i,
  input  logic [31:0]        delta_max_i,
  input  logic [31:0]        fx_rate_i,
  input  logic [31:0]        spread_min_i,
  input  logic [31:0]        spread_max_i,
  input  logic signed [31:0] regressed_gain_i,
  input  logic signed [31:0] underlying_performance_i,
  input  logic               last_underlying_i,
  output logic               empty,
  input  logic               pop,
  output logic [16:0]        element_smoothing_o,
  output logic [16:0]        path_smoothing_o,
  output logic signed [31:0] path_performance_o,
  output logic               path_done_o
);
  import bcss_pkg::*;

  cfg_t  cfg_q, cfg_d;
  item_t front_item, q_item;
  logic  q_empty, q_pop, res_valid, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_NOTIONAL: cfg_d.notional = pwdata[47:0];
        REG_GEARING:  cfg_d.gearing  = pwdata[31:0];
        REG_DOWN:     cfg_d.down     = pwdata[0];
        REG_OFF:      cfg_d.off      = pwdata[0];
        REG_MODE:     cfg_d.mode     = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_NOTIONAL: prdata = {16'd0, cfg_q.notional};
      REG_GEARING:  prdata = {32'd0, cfg_q.gearing};
      REG_DOWN:     prdata = {63'd0, cfg_q.down};
      REG_OFF:      prdata = {63'd0, cfg_q.off};
      REG_MODE:     prdata = {62'd0, cfg_q.mode};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.notional <= 48'h10000;
      cfg_q.gearing  <= 32'h10000;
      cfg_q.down     <= 1'b0;
      cfg_q.off      <= 1'b0;
      cfg_q.mode     <= MODE_MONO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bcss_front u_front (
    .action_i                 (action_i),
    .underlying_index_i       (underlying_index_i),
    .barrier_level_i          (barrier_level_i),
    .delta_max_i              (delta_max_i),
    .fx_rate_i                (fx_rate_i),
    .spread_min_i             (spread_min_i),
    .spread_max_i             (spread_max_i),
    .regressed_gain_i         (regressed_gain_i),
    .underlying_performance_i (underlying_performance_i),
    .last_underlying_i        (last_underlying_i),
    .item_o                   (front_item)
  );

  bcss_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  bcss_back #(
    .MAX_UNDERLYINGS (MAX_UNDERLYINGS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .q_empty_i           (q_empty),
    .q_data_i            (q_item),
    .q_pop_o             (q_pop),
    .res_valid_o         (res_valid),
    .res_pop_i           (pop),
    .element_smoothing_o (element_smoothing_o),
    .path_smoothing_o    (path_smoothing_o),
    .path_performance_o  (path_performance_o),
    .path_done_o         (path_done_o)
  );

  assign empty = !res_valid;

endmodule

/* rtl/bcss_checker.sv */
`include "barrier_call_spread_smoothing_defines.svh"

module bcss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               pready,
  input logic               empty,
  input logic               pop,
  input logic [16:0]        element_smoothing_o,
  input logic [16:0]        path_smoothing_o,
  input logic signed [31:0] path_performance_o,
  input logic               path_done_o
);

  `BCSS_ASSERT_IMP(a_open_path_zero, !empty && !path_done_o, path_smoothing_o == 17'd0 && path_performance_o == 32'sd0, "path fields set on an open path")
  `BCSS_ASSERT_IMP(a_smooth_range, !empty, element_smoothing_o <= 17'h10000 && path_smoothing_o <= 17'h10000, "smoothing above one")
  `BCSS_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(element_smoothing_o) && $stable(path_done_o), "waiting result changed")
  `BCSS_ASSERT_IMP(a_cfg_ready, psel, pready, "config access stalled")

endmodule

bind barrier_call_spread_smoothing bcss_checker u_bcss_checker (.*);
